// ===== src/sdt_pkg.sv =====
// Shared types and constants for the sorted descending table.
package sdt_pkg;

  localparam int DATA_W       = 32;
  localparam int CMD_W        = 2;
  localparam int POS_W        = 5;
  localparam int LVL_W        = 6;
  localparam int STAT_W       = 2;
  localparam int CAPACITY_DEF = 32;

  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL   = 2'd1;
  localparam logic [STAT_W-1:0] ST_BADPOS = 2'd2;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_SHIFT
  } cell_op_t;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  typedef struct packed {
    cell_op_t                  op;
    logic signed [DATA_W-1:0]  key;
  } cell_ctrl_t;

endpackage

// ===== src/sdt_cell.sv =====
// One storage cell of the sorted row: compares against the key and moves with its neighbors.
module sdt_cell (
  input  logic                              clk,
  input  sdt_pkg::cell_ctrl_t               ctrl,
  input  logic                              valid,
  input  logic                              prev_keep,
  input  logic signed [sdt_pkg::DATA_W-1:0] prev_value,
  input  logic signed [sdt_pkg::DATA_W-1:0] next_value,
  output logic signed [sdt_pkg::DATA_W-1:0] store,
  output logic                              keep,
  output logic                              eq
);
  import sdt_pkg::*;

  // keep: this entry stays in front of the key
  assign keep = valid && (store > ctrl.key);
  assign eq   = valid && (store == ctrl.key);

  always_ff @(posedge clk) begin
    case (ctrl.op)
      OP_INSERT: begin
        // the first cell that does not keep takes the key, the rest take the left neighbor
        if (!keep) begin
          store <= prev_keep ? ctrl.key : prev_value;
        end
      end
      OP_SHIFT: begin
        // close the gap: everything from the matching run onward moves left by one
        if (valid && !keep) begin
          store <= next_value;
        end
      end
      default: begin
        store <= store;
      end
    endcase
  end

endmodule

// ===== src/sdt_ctrl.sv =====
// Sequencer for the sorted table: request capture, fill count, remove loop and result register.
module sdt_ctrl #(
  parameter int CAPACITY = sdt_pkg::CAPACITY_DEF,
  parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [sdt_pkg::CMD_W-1:0]         command,
  input  logic signed [sdt_pkg::DATA_W-1:0] value,
  input  logic [sdt_pkg::POS_W-1:0]         position,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [sdt_pkg::STAT_W-1:0]        status,
  output logic [sdt_pkg::LVL_W-1:0]         fill_level,
  output logic [sdt_pkg::LVL_W-1:0]         removed_count,
  output logic signed [sdt_pkg::DATA_W-1:0] read_value,
  output sdt_pkg::cell_ctrl_t               cell_ctrl,
  output logic [CNT_W-1:0]                  count,
  output logic [sdt_pkg::POS_W-1:0]         req_pos,
  input  logic                              hit,
  input  logic signed [sdt_pkg::DATA_W-1:0] rd_data
);
  import sdt_pkg::*;

  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  state_t                    state;
  state_t                    state_next;
  logic [CMD_W-1:0]          req_cmd;
  logic signed [DATA_W-1:0]  req_key;
  logic [CNT_W-1:0]          removed;
  logic                      out_free;
  logic                      is_full;
  logic                      bad_pos;
  logic                      do_shift;
  logic                      finish;
  logic                      do_ins;
  logic [CNT_W-1:0]          count_after;

  assign out_free    = !out_valid || out_ready;
  assign is_full     = count >= CNT_W'(CAPACITY);
  assign bad_pos     = CMP_W'(req_pos) >= CMP_W'(count);
  assign do_shift    = (state == S_EXEC) && (req_cmd == CMD_REMOVE) && hit;
  assign finish      = (state == S_EXEC) && !do_shift && out_free;
  assign do_ins      = finish && (req_cmd == CMD_INSERT) && !is_full;
  assign count_after = do_ins ? count + 1'b1 : count;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (finish) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready      = (state == S_IDLE);
    cell_ctrl.key = req_key;
    if (do_shift) begin
      cell_ctrl.op = OP_SHIFT;
    end else if (do_ins) begin
      cell_ctrl.op = OP_INSERT;
    end else begin
      cell_ctrl.op = OP_HOLD;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      removed   <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (in_valid && in_ready) begin
        removed <= '0;
      end
      if (do_shift) begin
        count   <= count - 1'b1;
        removed <= removed + 1'b1;
      end
      if (do_ins) begin
        count <= count + 1'b1;
      end
      if (finish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // request and result payload
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_cmd <= command;
      req_key <= value;
      req_pos <= position;
    end
    if (finish) begin
      fill_level <= LVL_W'(count_after);
      case (req_cmd)
        CMD_INSERT: begin
          status        <= is_full ? ST_FULL : ST_OK;
          removed_count <= '0;
          read_value    <= '0;
        end
        CMD_REMOVE: begin
          status        <= ST_OK;
          removed_count <= LVL_W'(removed);
          read_value    <= '0;
        end
        CMD_READ: begin
          status        <= bad_pos ? ST_BADPOS : ST_OK;
          removed_count <= '0;
          read_value    <= bad_pos ? '0 : rd_data;
        end
        default: begin
          status        <= ST_OK;
          removed_count <= '0;
          read_value    <= '0;
        end
      endcase
    end
  end

endmodule

// ===== src/sorted_descending_table.sv =====
// Top level of the sorted descending table: sequencer and a row of storage cells.
//
//   channel | direction | handshake             | fields
//   --------+-----------+-----------------------+---------------------------------------------
//   in      | input     | in_valid / in_ready   | command, value, position
//   out     | output    | out_valid / out_ready | status, fill_level, removed_count, read_value
//
// Insert, read and unknown commands are accepted in S_IDLE and finish in S_EXEC, which
// registers the result and raises out_valid; the next request is taken back in S_IDLE.
// Remove stays in S_EXEC while a matching entry remains: the cell row
// drops one matching entry per cycle by shifting the tail left.
// Reset clears the fill count, the sequencer and the result valid; cells hold no reset
// and need no clearing pass.
// A request is taken while the last result still waits; its completion holds until
// the result register frees up, and a stalled result holds its value.
module sorted_descending_table #(
  parameter int CAPACITY = sdt_pkg::CAPACITY_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [sdt_pkg::CMD_W-1:0]         command,
  input  logic signed [sdt_pkg::DATA_W-1:0] value,
  input  logic [sdt_pkg::POS_W-1:0]         position,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [sdt_pkg::STAT_W-1:0]        status,
  output logic [sdt_pkg::LVL_W-1:0]         fill_level,
  output logic [sdt_pkg::LVL_W-1:0]         removed_count,
  output logic signed [sdt_pkg::DATA_W-1:0] read_value
);
  import sdt_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int RD_N  = (CAPACITY < (1 << POS_W)) ? CAPACITY : (1 << POS_W);

  cell_ctrl_t                cell_ctrl;
  logic [CNT_W-1:0]          count;
  logic [POS_W-1:0]          req_pos;
  logic                      hit;
  logic signed [DATA_W-1:0]  rd_data;
  logic signed [DATA_W-1:0]  store [CAPACITY];
  logic [CAPACITY-1:0]       keep_vec;
  logic [CAPACITY-1:0]       eq_vec;

  sdt_ctrl #(
    .CAPACITY (CAPACITY),
    .CNT_W    (CNT_W)
  ) u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .command       (command),
    .value         (value),
    .position      (position),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .status        (status),
    .fill_level    (fill_level),
    .removed_count (removed_count),
    .read_value    (read_value),
    .cell_ctrl     (cell_ctrl),
    .count         (count),
    .req_pos       (req_pos),
    .hit           (hit),
    .rd_data       (rd_data)
  );

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                     valid;
    logic                     prev_keep;
    logic signed [DATA_W-1:0] prev_value;
    logic signed [DATA_W-1:0] next_value;

    assign valid = count > CNT_W'(i);

    if (i == 0) begin : g_head
      assign prev_keep  = 1'b1;
      assign prev_value = cell_ctrl.key;
    end else begin : g_body
      assign prev_keep  = keep_vec[i-1];
      assign prev_value = store[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign next_value = '0;
    end else begin : g_mid
      assign next_value = store[i+1];
    end

    sdt_cell u_cell (
      .clk        (clk),
      .ctrl       (cell_ctrl),
      .valid      (valid),
      .prev_keep  (prev_keep),
      .prev_value (prev_value),
      .next_value (next_value),
      .store      (store[i]),
      .keep       (keep_vec[i]),
      .eq         (eq_vec[i])
    );
  end

  assign hit = |eq_vec;

  // only the ranks a position can reach feed the read select
  always_comb begin
    rd_data = '0;
    for (int i = 0; i < RD_N; i++) begin
      if (req_pos == POS_W'(i)) begin
        rd_data = store[i];
      end
    end
  end

endmodule

// ===== src/sdt_checker.sv =====
// Port-level checks on the sorted descending table, bound to the top level.
module sdt_checker #(
  parameter int CAPACITY = sdt_pkg::CAPACITY_DEF
) (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic [sdt_pkg::CMD_W-1:0]         command,
  input logic signed [sdt_pkg::DATA_W-1:0] value,
  input logic [sdt_pkg::POS_W-1:0]         position,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [sdt_pkg::STAT_W-1:0]        status,
  input logic [sdt_pkg::LVL_W-1:0]         fill_level,
  input logic [sdt_pkg::LVL_W-1:0]         removed_count,
  input logic signed [sdt_pkg::DATA_W-1:0] read_value
);
  import sdt_pkg::*;

  // a refused insert only happens with the store at capacity
  a_full_level: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_FULL) |-> (fill_level == LVL_W'(CAPACITY))
      && (removed_count == '0) && (read_value == '0))
    else $error("full status without a full store");

  a_badpos_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_BADPOS) |-> (read_value == '0) && (removed_count == '0))
    else $error("bad position result carries data");

  a_removed_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && (removed_count != '0) |-> (status == ST_OK) && (read_value == '0))
    else $error("remove result with wrong status or data");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(fill_level)
      && $stable(removed_count) && $stable(read_value))
    else $error("stalled result changed");

  a_reset_quiet: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result right after reset");

endmodule

bind sorted_descending_table sdt_checker #(.CAPACITY(CAPACITY)) u_sdt_checker (.*);

// ===== dv/tb.sv =====
// Testbench for the sorted descending table: directed and random command traffic against a shadow model.
module tb;
  import sdt_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 1900;
  localparam int IDLE_LIMIT   = 2000;
  localparam int TAIL_CYCLES  = 40;

  localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7fffffff;
  localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh80000000;

  typedef struct {
    logic [STAT_W-1:0]        status;
    logic [LVL_W-1:0]         fill;
    logic [LVL_W-1:0]         removed;
    logic signed [DATA_W-1:0] rd;
  } table_result_t;

  // Shadow copy of the table; predicts one result per accepted request.
  class table_scoreboard;
    logic signed [DATA_W-1:0] shadow_store [CAPACITY_DEF];
    int unsigned              shadow_count;
    table_result_t            expected_results [$];
    int                       fail_count;

    function new();
      shadow_count = 0;
      fail_count   = 0;
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    function int unsigned count();
      return shadow_count;
    endfunction

    function logic signed [DATA_W-1:0] sample_entry(logic signed [DATA_W-1:0] fallback);
      if (shadow_count == 0) return fallback;
      return shadow_store[$urandom_range(0, shadow_count - 1)];
    endfunction

    task report(string msg);
      fail_count++;
      $display("ERROR: %s", msg);
    endtask

    function void note_request(logic [CMD_W-1:0] cmd, logic signed [DATA_W-1:0] val,
                               logic [POS_W-1:0] pos);
      table_result_t res;
      int unsigned   at;
      int unsigned   w;
      res.status  = ST_OK;
      res.removed = '0;
      res.rd      = '0;
      case (cmd)
        CMD_INSERT: begin
          if (shadow_count >= CAPACITY_DEF) begin
            res.status = ST_FULL;
          end else begin
            at = shadow_count;
            for (int i = 0; i < shadow_count; i++) begin
              if (shadow_store[i] <= val) begin
                at = i;
                break;
              end
            end
            for (int i = shadow_count; i > at; i--) shadow_store[i] = shadow_store[i-1];
            shadow_store[at] = val;
            shadow_count++;
          end
        end
        CMD_REMOVE: begin
          w = 0;
          for (int i = 0; i < shadow_count; i++) begin
            if (shadow_store[i] == val) begin
              res.removed++;
            end else begin
              shadow_store[w] = shadow_store[i];
              w++;
            end
          end
          shadow_count = w;
        end
        CMD_READ: begin
          if (pos >= shadow_count) res.status = ST_BADPOS;
          else res.rd = shadow_store[pos];
        end
        default: ;
      endcase
      res.fill = shadow_count[LVL_W-1:0];
      expected_results.push_back(res);
    endfunction

    task check_result(logic [STAT_W-1:0] st, logic [LVL_W-1:0] fill,
                      logic [LVL_W-1:0] rem, logic signed [DATA_W-1:0] rd);
      table_result_t want;
      if (expected_results.size() == 0) begin
        report($sformatf("result st=%0d fill=%0d with no request outstanding", st, fill));
        return;
      end
      want = expected_results.pop_front();
      if (st !== want.status || fill !== want.fill || rem !== want.removed ||
          rd !== want.rd)
        report($sformatf("got st=%0d fill=%0d rem=%0d rd=%0d, want st=%0d fill=%0d rem=%0d rd=%0d",
                         st, fill, rem, rd, want.status, want.fill, want.removed, want.rd));
    endtask
  endclass

  logic                       clk;
  logic                       rst;
  logic                       in_valid;
  logic                       in_ready;
  logic [CMD_W-1:0]           command;
  logic signed [DATA_W-1:0]   value;
  logic [POS_W-1:0]           position;
  logic                       out_valid;
  logic                       out_ready;
  logic [STAT_W-1:0]          status;
  logic [LVL_W-1:0]           fill_level;
  logic [LVL_W-1:0]           removed_count;
  logic signed [DATA_W-1:0]   read_value;

  table_scoreboard sb;
  int              idle_cycles;
  int              burst_left;
  int              items_sent;

  sorted_descending_table dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .command       (command),
    .value         (value),
    .position      (position),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .status        (status),
    .fill_level    (fill_level),
    .removed_count (removed_count),
    .read_value    (read_value)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Receiver: switch between stall patterns every so often.
  initial begin
    int mode;
    int span;
    out_ready <= 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(16, 200);
      repeat (span) begin
        @(posedge clk);
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom_range(0, 1));
          2: out_ready <= ($urandom_range(0, 3) == 0);
          default: out_ready <= ($urandom_range(0, 9) == 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_result(status, fill_level, removed_count, read_value);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // Present one request and hold it until taken.
  task send_request(logic [CMD_W-1:0] cmd, logic signed [DATA_W-1:0] val,
                    logic [POS_W-1:0] pos);
    command  <= cmd;
    value    <= val;
    position <= pos;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    sb.note_request(cmd, val, pos);
    if (cmd != CMD_UNUSED) items_sent++;
  endtask

  task idle_gap(int n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Drop valid and hold off until every outstanding result is back.
  task wait_for_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    burst_left = $urandom_range(1, 60);
  endtask

  task pace();
    burst_left--;
    if (burst_left <= 0) begin
      idle_gap($urandom_range(1, 12));
      burst_left = $urandom_range(1, 60);
    end
  endtask

  function logic signed [DATA_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) return $signed($urandom_range(0, 6)) - 3;
    if (r == 5) begin
      case ($urandom_range(0, 4))
        0: return VAL_MAX;
        1: return VAL_MIN;
        2: return 32'sd0;
        3: return -32'sd1;
        default: return 32'sd1;
      endcase
    end
    return $urandom;
  endfunction

  function logic [POS_W-1:0] pick_position();
    int p;
    if ($urandom_range(0, 4) == 0) return POS_W'($urandom_range(0, 31));
    p = $urandom_range(0, sb.count());
    if (p > 31) p = 31;
    return POS_W'(p);
  endfunction

  // mode 0 fills, 1 drains, 2 mixes, 3 piles up copies of one value and removes them.
  task run_segment(int mode, int len);
    int                       r;
    int                       ins_lim;
    int                       rd_lim;
    int                       rem_lim;
    int                       n;
    logic signed [DATA_W-1:0] v;
    if (mode == 3) begin
      v = pick_value();
      n = $urandom_range(2, 12);
      repeat (n) begin
        send_request(CMD_INSERT, v, POS_W'($urandom_range(0, 31)));
        pace();
      end
      if ($urandom_range(0, 1)) begin
        send_request(CMD_READ, pick_value(), pick_position());
        pace();
      end
      send_request(CMD_REMOVE, v, POS_W'($urandom_range(0, 31)));
      pace();
      return;
    end
    case (mode)
      0: begin ins_lim = 70; rd_lim = 90; rem_lim = 96; end
      1: begin ins_lim = 20; rd_lim = 45; rem_lim = 95; end
      default: begin ins_lim = 40; rd_lim = 65; rem_lim = 92; end
    endcase
    repeat (len) begin
      r = $urandom_range(0, 99);
      if (r < ins_lim) begin
        send_request(CMD_INSERT, pick_value(), POS_W'($urandom_range(0, 31)));
      end else if (r < rd_lim) begin
        send_request(CMD_READ, pick_value(), pick_position());
      end else if (r < rem_lim) begin
        if ($urandom_range(0, 3) != 0) v = sb.sample_entry(pick_value());
        else v = pick_value();
        send_request(CMD_REMOVE, v, POS_W'($urandom_range(0, 31)));
      end else begin
        send_request(CMD_UNUSED, $urandom, POS_W'($urandom_range(0, 31)));
      end
      pace();
    end
  endtask

  initial begin
    int segs;
    sb          = new();
    idle_cycles = 0;
    items_sent  = 0;
    burst_left  = 8;
    rst      <= 1'b1;
    in_valid <= 1'b0;
    command  <= CMD_INSERT;
    value    <= '0;
    position <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty table, extremes, duplicates, reads past the end, unused code.
    send_request(CMD_READ, 32'sd0, 5'd0);
    send_request(CMD_REMOVE, 32'sd5, 5'd0);
    send_request(CMD_UNUSED, 32'sd0, 5'd0);
    send_request(CMD_INSERT, VAL_MAX, 5'd0);
    send_request(CMD_INSERT, VAL_MIN, 5'd31);
    send_request(CMD_INSERT, 32'sd0, 5'd0);
    send_request(CMD_INSERT, -32'sd1, 5'd0);
    send_request(CMD_INSERT, 32'sd0, 5'd0);
    for (int i = 0; i < 6; i++) send_request(CMD_READ, 32'sd0, POS_W'(i));
    send_request(CMD_READ, 32'sd0, 5'd31);
    send_request(CMD_REMOVE, 32'sd0, 5'd0);
    send_request(CMD_REMOVE, 32'sd12345, 5'd0);
    send_request(CMD_INSERT, VAL_MIN, 5'd0);
    send_request(CMD_REMOVE, VAL_MIN, 5'd0);
    send_request(CMD_READ, 32'sd0, 5'd0);
    send_request(CMD_UNUSED, -32'sd1, 5'd31);
    send_request(CMD_INSERT, 32'sd1, 5'd0);
    wait_for_results();

    items_sent = 0;
    run_segment(0, 50);
    segs = 0;
    while (items_sent < RANDOM_ITEMS) begin
      run_segment($urandom_range(0, 3), $urandom_range(20, 80));
      segs++;
      if (segs % 5 == 0) wait_for_results();
    end

    wait_for_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.fail_count == 0 && sb.pending() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
